>>> hw/rtl/csc_pkg.sv
// shared types, codes and constants of the color space pixel converter
package csc_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;

    // luminance weights, unsigned q0.16, summing to 65536
    localparam logic [15:0] WEIGHT_R = 16'd19595;
    localparam logic [15:0] WEIGHT_G = 16'd38470;
    localparam logic [15:0] WEIGHT_B = 16'd7471;

    localparam int PROD_W = 24;

    // operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // source space codes
    localparam logic [1:0] SPACE_GRAY = 2'd0;
    localparam logic [1:0] SPACE_RGB  = 2'd1;
    localparam logic [1:0] SPACE_CMYK = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_SPACE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEXED_MODE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  entry_address;
        logic [31:0] entry_data;
        logic [7:0]  comp0;
        logic [7:0]  comp1;
        logic [7:0]  comp2;
        logic [7:0]  comp3;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] gray;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] cyan;
        logic [7:0] magenta;
        logic [7:0] yellow;
        logic [7:0] black;
    } pixel_out_t;

    // weighted products and raw components after the multiply stage
    typedef struct packed {
        logic [PROD_W-1:0] prod0;
        logic [PROD_W-1:0] prod1;
        logic [PROD_W-1:0] prod2;
        logic [3:0][7:0]   comp;
        logic [7:0]        peak;
    } weigh_t;

endpackage

>>> hw/rtl/csc_table.sv
// decode table: four byte banks, one write port, one registered read per bank
module csc_table import csc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic [7:0]      wr_addr,
    input  logic [31:0]     wr_data,
    input  logic            rd_en,
    input  logic [3:0][7:0] rd_addr,
    output logic [3:0][7:0] rd_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic wr_hit;

    assign wr_hit = ({1'b0, wr_addr} < 9'(TABLE_DEPTH));

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [7:0] bank_mem [TABLE_DEPTH];
        logic [7:0] rd_q_reg;
        logic       rd_hit_reg;

        always_ff @(posedge aclk) begin
            if (wr_en && wr_hit) begin
                bank_mem[wr_addr[ADDR_W-1:0]] <= wr_data[8*j +: 8];
            end
            if (rd_en) begin
                rd_q_reg   <= bank_mem[rd_addr[j][ADDR_W-1:0]];
                rd_hit_reg <= ({1'b0, rd_addr[j]} < 9'(TABLE_DEPTH));
            end
        end

        // samples beyond the table read as zero
        assign rd_data[j] = rd_hit_reg ? rd_q_reg : 8'd0;
    end

endmodule

>>> hw/rtl/csc_weigh.sv
// multiply stage: luminance weight products and channel maximum
module csc_weigh import csc_pkg::*; (
    input  logic            aclk,
    input  logic            en,
    input  logic [3:0][7:0] comp,
    output weigh_t          weigh
);

    weigh_t     weigh_reg;
    weigh_t     weigh_next;
    logic [7:0] peak01;

    always_comb begin
        peak01            = (comp[1] > comp[0]) ? comp[1] : comp[0];
        weigh_next.prod0  = PROD_W'(WEIGHT_R * comp[0]);
        weigh_next.prod1  = PROD_W'(WEIGHT_G * comp[1]);
        weigh_next.prod2  = PROD_W'(WEIGHT_B * comp[2]);
        weigh_next.comp   = comp;
        weigh_next.peak   = (comp[2] > peak01) ? comp[2] : peak01;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            weigh_reg <= weigh_next;
        end
    end

    assign weigh = weigh_reg;

endmodule

>>> hw/rtl/csc_mix.sv
// output stage logic: luminance sum and per-space gray, rgb and cmyk forms
module csc_mix import csc_pkg::*; (
    input  weigh_t     weigh,
    input  logic [1:0] source_space,
    output pixel_out_t pixel
);

    function automatic logic [7:0] sub_from_white(input logic [8:0] v);
        logic [8:0] diff;
        begin
            diff = 9'd255 - v;
            sub_from_white = (v >= 9'd255) ? 8'd0 : diff[7:0];
        end
    endfunction

    logic [PROD_W:0] luma_sum;
    logic [7:0]      luma;
    logic [7:0]      c0;
    logic [7:0]      c1;
    logic [7:0]      c2;
    logic [7:0]      c3;

    always_comb begin
        c0       = weigh.comp[0];
        c1       = weigh.comp[1];
        c2       = weigh.comp[2];
        c3       = weigh.comp[3];
        luma_sum = {1'b0, weigh.prod0} + {1'b0, weigh.prod1} + {1'b0, weigh.prod2};
        luma     = luma_sum[PROD_W-1:PROD_W-8];

        unique case (source_space)
            SPACE_RGB: begin
                pixel.gray    = luma;
                pixel.red     = c0;
                pixel.green   = c1;
                pixel.blue    = c2;
                pixel.black   = ~weigh.peak;
                pixel.cyan    = weigh.peak - c0;
                pixel.magenta = weigh.peak - c1;
                pixel.yellow  = weigh.peak - c2;
            end
            SPACE_CMYK: begin
                pixel.gray    = sub_from_white({1'b0, c3} + {1'b0, luma});
                pixel.red     = sub_from_white({1'b0, c0} + {1'b0, c3});
                pixel.green   = sub_from_white({1'b0, c1} + {1'b0, c3});
                pixel.blue    = sub_from_white({1'b0, c2} + {1'b0, c3});
                pixel.cyan    = c0;
                pixel.magenta = c1;
                pixel.yellow  = c2;
                pixel.black   = c3;
            end
            default: begin
                // gray source, and the unused space code
                pixel.gray    = c0;
                pixel.red     = c0;
                pixel.green   = c0;
                pixel.blue    = c0;
                pixel.cyan    = 8'd0;
                pixel.magenta = 8'd0;
                pixel.yellow  = 8'd0;
                pixel.black   = ~c0;
            end
        endcase
    end

endmodule

>>> hw/rtl/color_space_pixel_convert.sv
// pixel color converter: decode table lookup, then gray, rgb and cmyk at once
// a convert word reaches m_ through the table read, multiply and output registers
// throughput: one word per cycle; each stage holds only while its successor is full
// load words write the decode table when accepted and produce no result
// aresetn (synchronous, active low) clears the stage valid bits and both registers
// table contents are undefined after reset until loaded
module color_space_pixel_convert import csc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // pixel and table load words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pixel_in_t              s_data,
    // converted pixels
    output logic                   m_valid,
    input  logic                   m_ready,
    output pixel_out_t             m_data,
    // register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [1:0] source_space_reg;
    logic       indexed_mode_reg;

    // stage valid bits: table read, multiply, output
    logic v1_reg;
    logic v2_reg;
    logic m_valid_reg;

    // per-stage advance, rippling back from the output register
    logic en1;
    logic en2;
    logic en3;

    logic            accept;
    logic            is_load;
    logic            is_convert;
    logic [3:0][7:0] rd_addr;
    logic [3:0][7:0] entry_bytes;
    weigh_t          weigh;
    pixel_out_t      pixel;
    pixel_out_t      m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_space_reg <= SPACE_GRAY;
            indexed_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SOURCE_SPACE: source_space_reg <= cfg_data[1:0];
                CFG_INDEXED_MODE: indexed_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // a stage takes new data when it is empty or its content moves on
    assign en3     = !m_valid_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign accept     = s_valid && s_ready;
    assign is_load    = accept && (s_data.operation == OP_LOAD);
    assign is_convert = accept && (s_data.operation == OP_CONVERT);

    // palette mode: comp0 selects the entry for every bank
    always_comb begin
        rd_addr[0] = s_data.comp0;
        rd_addr[1] = indexed_mode_reg ? s_data.comp0 : s_data.comp1;
        rd_addr[2] = indexed_mode_reg ? s_data.comp0 : s_data.comp2;
        rd_addr[3] = indexed_mode_reg ? s_data.comp0 : s_data.comp3;
    end

    // stage 1: table write on load, registered bank reads on convert
    csc_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (is_load),
        .wr_addr (s_data.entry_address),
        .wr_data (s_data.entry_data),
        .rd_en   (en1),
        .rd_addr (rd_addr),
        .rd_data (entry_bytes)
    );

    // stage 2: weight products and channel maximum
    csc_weigh u_weigh (
        .aclk  (aclk),
        .en    (en2),
        .comp  (entry_bytes),
        .weigh (weigh)
    );

    // stage 3: combine per source space into the output register
    csc_mix u_mix (
        .weigh        (weigh),
        .source_space (source_space_reg),
        .pixel        (pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= is_convert;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            m_data_reg <= pixel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> dv/tb_color_space_pixel_convert.sv
// testbench of the color space pixel converter: directed table, then random traffic
`timescale 1ns / 100ps

module tb_color_space_pixel_convert import csc_pkg::*;;

    // source space code three has no name in the package; the block treats it as gray
    localparam logic [1:0] SPACE_SPARE = 2'd3;

    localparam int SEGMENTS          = 8;
    localparam int WORDS_PER_SEGMENT = 94;
    localparam int PRESSURE_CYCLES   = 150;
    localparam int SETTLE_CYCLES     = 8;   // a margin over the pipeline latency
    localparam int LIMIT_NS          = 2_000_000;

    // whole-pixel results that can be read off at a glance: gray,r,g,b,c,m,y,k
    localparam pixel_out_t PIX_BLACK    = 64'h00000000_000000FF;
    localparam pixel_out_t PIX_WHITE    = 64'hFFFFFFFF_00000000;
    localparam pixel_out_t PIX_FULL_INK = 64'h00000000_FFFFFFFF;
    localparam pixel_out_t PIX_NONE     = 64'h0;

    // one row of the directed table: register setting, word, optional typed-in result
    typedef struct packed {
        logic [1:0]  space;
        logic        indexed;
        logic        op;
        logic [7:0]  addr;
        logic [31:0] data;
        logic [7:0]  c0;
        logic [7:0]  c1;
        logic [7:0]  c2;
        logic [7:0]  c3;
        logic        has_golden;
        pixel_out_t  golden;
    } vector_t;

    typedef struct {
        bit         has_golden;
        pixel_out_t golden;
    } golden_note_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    pixel_in_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    pixel_out_t             m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // mirror of the block: decode table and both registers
    bit   [7:0] decode_bank [4][256];
    logic [1:0] space_q;
    logic       indexed_q;

    // pixels still owed by the block, oldest first
    pixel_out_t   pixels_due [$];
    // one note per offered word, popped when the word is taken
    golden_note_t golden_notes [$];

    // stimulus side bookkeeping: which entries hold data, current setting
    bit         entry_loaded [256];
    logic [7:0] loaded_addrs [$];
    logic [1:0] cur_space;
    logic       cur_indexed;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  pressure_go;
    bit  pressure_served;
    int  error_count;

    golden_note_t note_now;
    pixel_out_t   due_now;
    logic [7:0][7:0] due_bytes;
    logic [7:0][7:0] got_bytes;
    string field_names [8] = '{"gray", "red", "green", "blue",
                               "cyan", "magenta", "yellow", "black"};

    // directed rows: extremes first, then each space, the spare code and indexed mode
    vector_t directed_vectors [0:23] = '{
        // table loads; comp fields carry junk that must be ignored
        '{SPACE_GRAY, 1'b0, OP_LOAD, 8'h00, 32'h0000_0000,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, PIX_NONE},
        '{SPACE_GRAY, 1'b0, OP_LOAD, 8'hFF, 32'hFFFF_FFFF,
          8'h00, 8'h00, 8'h00, 8'h00, 1'b0, PIX_NONE},
        '{SPACE_GRAY, 1'b0, OP_LOAD, 8'hA5, 32'h80FF_4010,
          8'h5A, 8'h5A, 8'h5A, 8'h5A, 1'b0, PIX_NONE},
        '{SPACE_GRAY, 1'b0, OP_LOAD, 8'h01, 32'h0000_00FF,
          8'hC3, 8'h3C, 8'hC3, 8'h3C, 1'b0, PIX_NONE},
        // gray source right after reset; entry fields of a convert are ignored
        '{SPACE_GRAY, 1'b0, OP_CONVERT, 8'hFF, 32'hFFFF_FFFF,
          8'h00, 8'h00, 8'h00, 8'h00, 1'b1, PIX_BLACK},
        '{SPACE_GRAY, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, PIX_WHITE},
        // unused components point at entries never loaded
        '{SPACE_GRAY, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hA5, 8'h33, 8'h33, 8'h33, 1'b0, PIX_NONE},
        // rgb source
        '{SPACE_RGB, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'hFF, 8'hFF, 8'h33, 1'b1, PIX_WHITE},
        '{SPACE_RGB, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'h00, 8'h00, 8'h00, 8'h33, 1'b1, PIX_BLACK},
        '{SPACE_RGB, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'h01, 8'h00, 8'h00, 8'h33, 1'b0, PIX_NONE},
        '{SPACE_RGB, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hA5, 8'h00, 8'hFF, 8'h33, 1'b0, PIX_NONE},
        // cmyk source, including the saturating corners
        '{SPACE_CMYK, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, PIX_FULL_INK},
        '{SPACE_CMYK, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'h00, 8'h00, 8'h00, 8'h00, 1'b1, PIX_WHITE},
        '{SPACE_CMYK, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hA5, 8'hA5, 8'hA5, 8'hA5, 1'b0, PIX_NONE},
        '{SPACE_CMYK, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'h00, 8'h00, 8'hA5, 1'b0, PIX_NONE},
        // spare space code behaves as gray
        '{SPACE_SPARE, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'h33, 8'h33, 8'h33, 1'b1, PIX_WHITE},
        '{SPACE_SPARE, 1'b0, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hA5, 8'h33, 8'h33, 8'h33, 1'b0, PIX_NONE},
        // indexed mode: comp0 picks the whole entry, the rest is ignored
        '{SPACE_RGB, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hA5, 8'h77, 8'h77, 8'h77, 1'b0, PIX_NONE},
        '{SPACE_RGB, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'h77, 8'h77, 8'h77, 1'b1, PIX_WHITE},
        '{SPACE_CMYK, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'h00, 8'h77, 8'h77, 8'h77, 1'b1, PIX_WHITE},
        '{SPACE_CMYK, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hFF, 8'h77, 8'h77, 8'h77, 1'b1, PIX_FULL_INK},
        '{SPACE_CMYK, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'hA5, 8'h77, 8'h77, 8'h77, 1'b0, PIX_NONE},
        '{SPACE_GRAY, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'h00, 8'h77, 8'h77, 8'h77, 1'b1, PIX_BLACK},
        '{SPACE_GRAY, 1'b1, OP_CONVERT, 8'h00, 32'h0000_0000,
          8'h01, 8'h77, 8'h77, 8'h77, 1'b1, PIX_WHITE}
    };

    color_space_pixel_convert u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // a - b, floored at zero
    function automatic int unsigned floor_sub(input int unsigned a, input int unsigned b);
        return (b >= a) ? 0 : a - b;
    endfunction

    // expected pixel for a convert word, from the mirrored table and registers
    function automatic pixel_out_t convert_pixel(input pixel_in_t w);
        logic [7:0]  sel [4];
        int unsigned p [4];
        int unsigned luma;
        int unsigned peak;
        pixel_out_t  o;
        sel[0] = w.comp0;
        sel[1] = indexed_q ? w.comp0 : w.comp1;
        sel[2] = indexed_q ? w.comp0 : w.comp2;
        sel[3] = indexed_q ? w.comp0 : w.comp3;
        for (int j = 0; j < 4; j++)
            p[j] = decode_bank[j][sel[j]];
        case (space_q)
            SPACE_RGB: begin
                luma = (WEIGHT_R * p[0] + WEIGHT_G * p[1] + WEIGHT_B * p[2]) >> 16;
                peak = p[0];
                if (p[1] > peak) peak = p[1];
                if (p[2] > peak) peak = p[2];
                o.gray    = luma[7:0];
                o.red     = p[0][7:0];
                o.green   = p[1][7:0];
                o.blue    = p[2][7:0];
                o.black   = 8'(255 - peak);
                o.cyan    = 8'(peak - p[0]);
                o.magenta = 8'(peak - p[1]);
                o.yellow  = 8'(peak - p[2]);
            end
            SPACE_CMYK: begin
                luma = (WEIGHT_R * p[0] + WEIGHT_G * p[1] + WEIGHT_B * p[2]) >> 16;
                o.gray    = 8'(floor_sub(255, p[3] + luma));
                o.red     = 8'(floor_sub(255, p[0] + p[3]));
                o.green   = 8'(floor_sub(255, p[1] + p[3]));
                o.blue    = 8'(floor_sub(255, p[2] + p[3]));
                o.cyan    = p[0][7:0];
                o.magenta = p[1][7:0];
                o.yellow  = p[2][7:0];
                o.black   = p[3][7:0];
            end
            default: begin
                // gray, and the spare code
                o.gray    = p[0][7:0];
                o.red     = p[0][7:0];
                o.green   = p[0][7:0];
                o.blue    = p[0][7:0];
                o.cyan    = 8'd0;
                o.magenta = 8'd0;
                o.yellow  = 8'd0;
                o.black   = 8'(255 - p[0]);
            end
        endcase
        return o;
    endfunction

    // monitor: mirror register and table writes, predict, and check results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SOURCE_SPACE)
                    space_q = cfg_data[1:0];
                else
                    indexed_q = cfg_data[0];
            end
            if (s_valid && s_ready) begin
                note_now = golden_notes.pop_front();
                if (s_data.operation == OP_LOAD) begin
                    for (int j = 0; j < 4; j++)
                        decode_bank[j][s_data.entry_address] = s_data.entry_data[8*j +: 8];
                end else begin
                    pixels_due.push_back(note_now.has_golden ? note_now.golden
                                                             : convert_pixel(s_data));
                end
            end
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: pixel %h with none expected", $time, m_data);
                    error_count++;
                end else begin
                    due_now = pixels_due.pop_front();
                    if (due_now !== m_data) begin
                        error_count++;
                        due_bytes = due_now;
                        got_bytes = m_data;
                        // gray sits in the top byte, black in the bottom one
                        for (int i = 0; i < 8; i++)
                            if (due_bytes[7-i] !== got_bytes[7-i])
                                $display("%0t: %s expected %0d got %0d", $time,
                                         field_names[i], due_bytes[7-i], got_bytes[7-i]);
                    end
                end
            end
        end
    end

    // result side: random stalls, plus one long hold-off to back the block up
    initial begin
        m_ready = 1'b0;
        pressure_served = 1'b0;
        forever begin
            if (pressure_go && !pressure_served) begin
                pressure_served = 1'b1;
                m_ready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
                @(posedge aclk);
            end
        end
    end

    // offer one word, with random gaps ahead of it, and wait until it is taken
    task automatic send_word(input pixel_in_t w, input bit has_golden, input pixel_out_t golden);
        golden_note_t n;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        n.has_golden = has_golden;
        n.golden     = golden;
        golden_notes.push_back(n);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk iff (s_valid && s_ready));
    endtask

    // register writes only once the block has gone quiet
    task automatic configure(input logic [1:0] space, input logic indexed);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SOURCE_SPACE;
        cfg_data  <= space;
        @(posedge aclk iff (cfg_valid && cfg_ready));
        cfg_index <= CFG_INDEXED_MODE;
        cfg_data  <= {1'b0, indexed};
        @(posedge aclk iff (cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        cur_space   = space;
        cur_indexed = indexed;
    endtask

    function automatic void note_load(input logic [7:0] addr);
        if (!entry_loaded[addr]) begin
            entry_loaded[addr] = 1'b1;
            loaded_addrs.push_back(addr);
        end
    endfunction

    // table bytes lean toward the extremes so that the saturating paths get hit
    function automatic logic [7:0] table_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // random word: a quarter loads, the rest converts that read loaded entries only
    function automatic pixel_in_t make_random_word();
        pixel_in_t w;
        int        used;
        logic [7:0] comps [4];
        w.entry_address = 8'($urandom);
        w.entry_data    = {table_byte(), table_byte(), table_byte(), table_byte()};
        if ($urandom_range(0, 3) == 0) begin
            w.operation = OP_LOAD;
            for (int j = 0; j < 4; j++)
                comps[j] = 8'($urandom);
            note_load(w.entry_address);
        end else begin
            w.operation = OP_CONVERT;
            if (cur_indexed)
                used = 1;
            else if (cur_space == SPACE_CMYK)
                used = 4;
            else if (cur_space == SPACE_RGB)
                used = 3;
            else
                used = 1;
            // components the setting does not read may point anywhere
            for (int j = 0; j < 4; j++)
                comps[j] = (j < used) ? loaded_addrs[$urandom_range(0, loaded_addrs.size() - 1)]
                                      : 8'($urandom);
        end
        w.comp0 = comps[0];
        w.comp1 = comps[1];
        w.comp2 = comps[2];
        w.comp3 = comps[3];
        return w;
    endfunction

    // main sequence: reset, directed table, random segments, drain, verdict
    initial begin
        vector_t   row;
        pixel_in_t w;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        space_q        = SPACE_GRAY;
        indexed_q      = 1'b0;
        cur_space      = SPACE_GRAY;
        cur_indexed    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b0;
        error_count    = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, switching registers between rows where needed
        for (int i = 0; i < $size(directed_vectors); i++) begin
            row = directed_vectors[i];
            if (row.space != cur_space || row.indexed != cur_indexed)
                configure(row.space, row.indexed);
            w.operation     = row.op;
            w.entry_address = row.addr;
            w.entry_data    = row.data;
            w.comp0         = row.c0;
            w.comp1         = row.c1;
            w.comp2         = row.c2;
            w.comp3         = row.c3;
            if (row.op == OP_LOAD)
                note_load(row.addr);
            send_word(w, row.has_golden, row.golden);
        end

        // random segments; idling cycles through none, sender, receiver, both light
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            for (int n = 0; n < WORDS_PER_SEGMENT; n++) begin
                // long receiver hold-off while words keep coming, so the input backs up
                if (seg == 0 && n == 30)
                    pressure_go = 1'b1;
                send_word(make_random_word(), 1'b0, PIX_NONE);
            end
        end

        // drain, then wait out the settle time so that any stray result shows
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && pixels_due.size() == 0)
            $display("tb_color_space_pixel_convert OK");
        else
            $display("tb_color_space_pixel_convert NOT OK");
        $finish;
    end

    // hang guard
    initial begin
        #(LIMIT_NS);
        $display("%0t: timeout", $time);
        $display("tb_color_space_pixel_convert NOT OK");
        $finish;
    end

endmodule
